// ===== sv/rrt_nearest_extend_core_defines.svh =====
// Assertion macros shared by the tree-extension RTL.
// Needs a clk and an active-low rst_n in the module that uses them.
`ifndef RRT_NEAREST_EXTEND_CORE_DEFINES_SVH
`define RRT_NEAREST_EXTEND_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define RRTNE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rrtne assertion failed");
`define RRTNE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrtne assertion failed");
`else
`define RRTNE_ASSERT_IMPL(label, ante, cons)
`define RRTNE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== sv/rrtne_pkg.sv =====
// Shared constants, state codes and request types of the tree-extension block.
// No dependencies.
package rrtne_pkg;
  localparam int MAX_NODES = 4096;
  localparam int COORD_W   = 16;
  localparam int SLOT_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = SLOT_W + 1;
  localparam int SQ_W      = 2 * COORD_W;
  localparam int DIST_W    = 2 * COORD_W + 1;
  localparam int CFG_AW    = 5;

  localparam logic OP_RESTART = 1'b0;
  localparam logic OP_SAMPLE  = 1'b1;

  typedef enum logic [2:0] {
    REG_START_X  = 3'd0,
    REG_START_Y  = 3'd1,
    REG_GOAL_X   = 3'd2,
    REG_GOAL_Y   = 3'd3,
    REG_STEP     = 3'd4,
    REG_RADIUS   = 3'd5,
    REG_WORLD_W  = 3'd6,
    REG_WORLD_H  = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    T_IDLE, T_SCAN, T_DECIDE, T_STEP_X, T_STEP_Y, T_WRITE, T_GOAL1, T_GOAL2
  } top_state_t;

  typedef enum logic [2:0] {
    S_IDLE, S_MAG, S_MUL, S_DIV, S_SQRT, S_DONE
  } step_state_t;

  typedef struct packed {
    logic               go;
    logic [COORD_W-1:0] from;
    logic [COORD_W-1:0] to;
    logic [DIST_W-1:0]  d2;
    logic [SQ_W-1:0]    s2;
  } step_req_t;

  typedef struct packed {
    logic               done;
    logic [COORD_W-1:0] coord;
  } step_rsp_t;
endpackage

// ===== sv/rrtne_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module rrtne_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // read old data on a write, read registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== sv/rrtne_step.sv =====
// Step-point unit: one coordinate of the point one step from the nearest node.
// Multiplies, divides bit by bit, then takes an integer root. Uses rrtne_pkg.
`include "rrt_nearest_extend_core_defines.svh"
module rrtne_step (
  input  logic                clk,
  input  logic                rst_n,
  input  rrtne_pkg::step_req_t req,
  output rrtne_pkg::step_rsp_t rsp
);
  import rrtne_pkg::*;

  step_state_t        state_r, state_nxt;
  logic [COORD_W-1:0] from_r, from_nxt, to_r, to_nxt, coord_r, coord_nxt;
  logic [DIST_W-1:0]  d2_r, d2_nxt;
  logic [SQ_W-1:0]    s2_r, s2_nxt, mag2_r, mag2_nxt;
  logic [DIST_W:0]    rem_r, rem_nxt;
  logic [SQ_W-1:0]    numlo_r, numlo_nxt, quo_r, quo_nxt;
  logic [SQ_W-1:0]    sqv_r, sqv_nxt, sqres_r, sqres_nxt, sqbit_r, sqbit_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic [COORD_W-1:0] mag;
  logic [2*SQ_W-1:0]  prod;
  logic [DIST_W:0]    sh;
  logic               ge;
  logic [SQ_W-1:0]    trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    from_r  <= from_nxt;
    to_r    <= to_nxt;
    coord_r <= coord_nxt;
    d2_r    <= d2_nxt;
    s2_r    <= s2_nxt;
    mag2_r  <= mag2_nxt;
    rem_r   <= rem_nxt;
    numlo_r <= numlo_nxt;
    quo_r   <= quo_nxt;
    sqv_r   <= sqv_nxt;
    sqres_r <= sqres_nxt;
    sqbit_r <= sqbit_nxt;
    cnt_r   <= cnt_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    from_nxt  = from_r;
    to_nxt    = to_r;
    coord_nxt = coord_r;
    d2_nxt    = d2_r;
    s2_nxt    = s2_r;
    mag2_nxt  = mag2_r;
    rem_nxt   = rem_r;
    numlo_nxt = numlo_r;
    quo_nxt   = quo_r;
    sqv_nxt   = sqv_r;
    sqres_nxt = sqres_r;
    sqbit_nxt = sqbit_r;
    cnt_nxt   = cnt_r;
    mag   = (to_r >= from_r) ? to_r - from_r : from_r - to_r;
    prod  = s2_r * mag2_r;
    sh    = {rem_r[DIST_W-1:0], numlo_r[SQ_W-1]};
    ge    = sh >= {1'b0, d2_r};
    trial = sqres_r + sqbit_r;
    rsp.done  = 1'b0;
    rsp.coord = coord_r;
    unique case (state_r)
      S_IDLE, S_DONE: begin
        rsp.done  = (state_r == S_DONE);
        state_nxt = S_IDLE;
        if (req.go) begin
          from_nxt  = req.from;
          to_nxt    = req.to;
          d2_nxt    = req.d2;
          s2_nxt    = req.s2;
          state_nxt = S_MAG;
        end
      end
      // square the offset magnitude
      S_MAG: begin
        mag2_nxt  = mag * mag;
        state_nxt = S_MUL;
      end
      // form step^2 * mag^2; its high half already lies below d2
      S_MUL: begin
        rem_nxt   = {2'b00, prod[2*SQ_W-1:SQ_W]};
        numlo_nxt = prod[SQ_W-1:0];
        quo_nxt   = '0;
        cnt_nxt   = 5'd31;
        state_nxt = S_DIV;
      end
      // one quotient bit per cycle
      S_DIV: begin
        rem_nxt   = ge ? sh - {1'b0, d2_r} : sh;
        quo_nxt   = {quo_r[SQ_W-2:0], ge};
        numlo_nxt = {numlo_r[SQ_W-2:0], 1'b0};
        cnt_nxt   = cnt_r - 5'd1;
        if (cnt_r == '0) begin
          sqv_nxt   = {quo_r[SQ_W-2:0], ge};
          sqres_nxt = '0;
          sqbit_nxt = SQ_W'(1) << (SQ_W - 2);
          cnt_nxt   = 5'd15;
          state_nxt = S_SQRT;
        end
      end
      // one root bit per cycle, then apply the sign of the offset
      S_SQRT: begin
        if (sqv_r >= trial) begin
          sqv_nxt   = sqv_r - trial;
          sqres_nxt = (sqres_r >> 1) + sqbit_r;
        end else begin
          sqres_nxt = sqres_r >> 1;
        end
        sqbit_nxt = sqbit_r >> 2;
        cnt_nxt   = cnt_r - 5'd1;
        if (cnt_r == '0) begin
          coord_nxt = (to_r >= from_r) ? from_r + sqres_nxt[COORD_W-1:0]
                                       : from_r - sqres_nxt[COORD_W-1:0];
          state_nxt = S_DONE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `RRTNE_ASSERT_IMPL(a_go_free, req.go, state_r == S_IDLE || state_r == S_DONE)
  `RRTNE_ASSERT_IMPL(a_rem_below, state_r == S_DIV, rem_r < (DIST_W+1)'(d2_r))
  `RRTNE_ASSERT_NEXT(a_done_once, rsp.done, !rsp.done)
endmodule

// ===== sv/rrt_nearest_extend_core.sv =====
// Rapidly exploring random tree extension block, top level.
// Item channel: drive in_op / in_sample_x / in_sample_y with start while busy
// is low; the request is taken at that edge. in_op restart (0) stores the
// start register as root in slot 0; an in-world sample (1) on a non-empty tree
// scans all stored nodes for the nearest one and, if the sample lies beyond the
// step length and the table is not full, appends a node one step towards it.
// Results: out_valid strobes for one cycle with all out_ fields; the receiver
// cannot stall and must take them then. Exactly one result per request.
// When a node is added, the step unit runs twice, once per coordinate, each
// pass a bit-serial divider followed by an integer root.
// The node scan is set by the point memory's single read port: one node a
// cycle. busy stays high until the result strobe.
// Configuration: APB port, registers at byte addresses 4*i, written only while
// idle by the user (not enforced by the block). Reset clears the control state
// and node count, not the point memory: only entries below the count are read.
// Uses rrtne_pkg, rrtne_ram, rrtne_step.
`include "rrt_nearest_extend_core_defines.svh"
module rrt_nearest_extend_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_op,
  input  logic [rrtne_pkg::COORD_W-1:0]     in_sample_x,
  input  logic [rrtne_pkg::COORD_W-1:0]     in_sample_y,
  output logic                              out_valid,
  output logic                              out_added,
  output logic [rrtne_pkg::COORD_W-1:0]     out_new_x,
  output logic [rrtne_pkg::COORD_W-1:0]     out_new_y,
  output logic [rrtne_pkg::SLOT_W-1:0]      out_new_slot,
  output logic [rrtne_pkg::SLOT_W-1:0]      out_parent_slot,
  output logic                              out_goal_reached,
  output logic                              out_table_full,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rrtne_pkg::CFG_AW-1:0]      paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import rrtne_pkg::*;

  // configuration registers
  logic [COORD_W-1:0] start_x_r, start_y_r, goal_x_r, goal_y_r;
  logic [COORD_W-1:0] step_r, radius_r, world_w_r, world_h_r;
  reg_idx_t           cfg_idx;
  logic               cfg_wr;
  logic [COORD_W-1:0] cfg_rd;

  top_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]   node_cnt_r, node_cnt_nxt, rd_idx_r, rd_idx_nxt;
  logic [COORD_W-1:0] last_x_r, last_x_nxt, last_y_r, last_y_nxt;
  logic [COORD_W-1:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic [SQ_W-1:0]    s2_r, s2_nxt;
  logic               p1_v_r, p1_v_nxt, p2_v_r, p2_v_nxt;
  logic [SLOT_W-1:0]  p1_idx_r, p1_idx_nxt, p2_idx_r, p2_idx_nxt;
  logic [COORD_W-1:0] p2_px_r, p2_px_nxt, p2_py_r, p2_py_nxt;
  logic [SQ_W-1:0]    p2_dx2_r, p2_dx2_nxt, p2_dy2_r, p2_dy2_nxt;
  logic [DIST_W-1:0]  best_d_r, best_d_nxt, cand_d;
  logic [SLOT_W-1:0]  best_idx_r, best_idx_nxt;
  logic [COORD_W-1:0] best_x_r, best_x_nxt, best_y_r, best_y_nxt;
  logic               added_r, added_nxt, full_r, full_nxt;
  logic [COORD_W-1:0] nx_r, nx_nxt, ny_r, ny_nxt;
  logic [SLOT_W-1:0]  nslot_r, nslot_nxt, pslot_r, pslot_nxt;
  logic [SQ_W-1:0]    gdx2_r, gdx2_nxt, gdy2_r, gdy2_nxt, r2_r, r2_nxt;
  logic               outv_r, outv_nxt;
  logic               o_added_r, o_goal_r, o_full_r;
  logic               o_added_nxt, o_goal_nxt, o_full_nxt;
  logic [COORD_W-1:0] o_nx_r, o_nx_nxt, o_ny_r, o_ny_nxt;
  logic [SLOT_W-1:0]  o_nslot_r, o_nslot_nxt, o_pslot_r, o_pslot_nxt;
  logic               mem_we, issue;
  logic [SLOT_W-1:0]  mem_addr;
  logic [SQ_W-1:0]    mem_wdata, mem_rdata;
  logic [COORD_W-1:0] mem_px, mem_py, dx, dy, gdx, gdy;
  step_req_t          sreq;
  step_rsp_t          srsp;

  // APB register file
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = {{(32-COORD_W){1'b0}}, cfg_rd};

  always_comb begin
    unique case (cfg_idx)
      REG_START_X: cfg_rd = start_x_r;
      REG_START_Y: cfg_rd = start_y_r;
      REG_GOAL_X:  cfg_rd = goal_x_r;
      REG_GOAL_Y:  cfg_rd = goal_y_r;
      REG_STEP:    cfg_rd = step_r;
      REG_RADIUS:  cfg_rd = radius_r;
      REG_WORLD_W: cfg_rd = world_w_r;
      REG_WORLD_H: cfg_rd = world_h_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r <= '0;
      start_y_r <= '0;
      goal_x_r  <= '0;
      goal_y_r  <= '0;
      step_r    <= COORD_W'(768);
      radius_r  <= COORD_W'(256);
      world_w_r <= '1;
      world_h_r <= '1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_START_X: start_x_r <= pwdata[COORD_W-1:0];
        REG_START_Y: start_y_r <= pwdata[COORD_W-1:0];
        REG_GOAL_X:  goal_x_r  <= pwdata[COORD_W-1:0];
        REG_GOAL_Y:  goal_y_r  <= pwdata[COORD_W-1:0];
        REG_STEP:    step_r    <= pwdata[COORD_W-1:0];
        REG_RADIUS:  radius_r  <= pwdata[COORD_W-1:0];
        REG_WORLD_W: world_w_r <= pwdata[COORD_W-1:0];
        REG_WORLD_H: world_h_r <= pwdata[COORD_W-1:0];
      endcase
    end
  end

  // point memory: x in the high half, y in the low half
  rrtne_ram #(.WIDTH(SQ_W), .DEPTH(MAX_NODES)) u_points (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  rrtne_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sreq),
    .rsp   (srsp)
  );

  assign mem_px = mem_rdata[SQ_W-1:COORD_W];
  assign mem_py = mem_rdata[COORD_W-1:0];
  assign dx     = (sx_r >= mem_px) ? sx_r - mem_px : mem_px - sx_r;
  assign dy     = (sy_r >= mem_py) ? sy_r - mem_py : mem_py - sy_r;
  assign cand_d = {1'b0, p2_dx2_r} + {1'b0, p2_dy2_r};
  assign gdx    = (last_x_r >= goal_x_r) ? last_x_r - goal_x_r : goal_x_r - last_x_r;
  assign gdy    = (last_y_r >= goal_y_r) ? last_y_r - goal_y_r : goal_y_r - last_y_r;
  assign issue  = (state_r == T_SCAN) && (rd_idx_r < node_cnt_r);

  assign busy             = (state_r != T_IDLE);
  assign out_valid        = outv_r;
  assign out_added        = o_added_r;
  assign out_new_x        = o_nx_r;
  assign out_new_y        = o_ny_r;
  assign out_new_slot     = o_nslot_r;
  assign out_parent_slot  = o_pslot_r;
  assign out_goal_reached = o_goal_r;
  assign out_table_full   = o_full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= T_IDLE;
      node_cnt_r <= '0;
      last_x_r   <= '0;
      last_y_r   <= '0;
      p1_v_r     <= 1'b0;
      p2_v_r     <= 1'b0;
      outv_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      node_cnt_r <= node_cnt_nxt;
      last_x_r   <= last_x_nxt;
      last_y_r   <= last_y_nxt;
      p1_v_r     <= p1_v_nxt;
      p2_v_r     <= p2_v_nxt;
      outv_r     <= outv_nxt;
    end
    rd_idx_r    <= rd_idx_nxt;
    sx_r        <= sx_nxt;
    sy_r        <= sy_nxt;
    s2_r        <= s2_nxt;
    p1_idx_r    <= p1_idx_nxt;
    p2_idx_r    <= p2_idx_nxt;
    p2_px_r     <= p2_px_nxt;
    p2_py_r     <= p2_py_nxt;
    p2_dx2_r    <= p2_dx2_nxt;
    p2_dy2_r    <= p2_dy2_nxt;
    best_d_r    <= best_d_nxt;
    best_idx_r  <= best_idx_nxt;
    best_x_r    <= best_x_nxt;
    best_y_r    <= best_y_nxt;
    added_r     <= added_nxt;
    full_r      <= full_nxt;
    nx_r        <= nx_nxt;
    ny_r        <= ny_nxt;
    nslot_r     <= nslot_nxt;
    pslot_r     <= pslot_nxt;
    gdx2_r      <= gdx2_nxt;
    gdy2_r      <= gdy2_nxt;
    r2_r        <= r2_nxt;
    o_added_r   <= o_added_nxt;
    o_goal_r    <= o_goal_nxt;
    o_full_r    <= o_full_nxt;
    o_nx_r      <= o_nx_nxt;
    o_ny_r      <= o_ny_nxt;
    o_nslot_r   <= o_nslot_nxt;
    o_pslot_r   <= o_pslot_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    node_cnt_nxt = node_cnt_r;
    last_x_nxt   = last_x_r;
    last_y_nxt   = last_y_r;
    rd_idx_nxt   = rd_idx_r;
    sx_nxt       = sx_r;
    sy_nxt       = sy_r;
    s2_nxt       = s2_r;
    best_d_nxt   = best_d_r;
    best_idx_nxt = best_idx_r;
    best_x_nxt   = best_x_r;
    best_y_nxt   = best_y_r;
    added_nxt    = added_r;
    full_nxt     = full_r;
    nx_nxt       = nx_r;
    ny_nxt       = ny_r;
    nslot_nxt    = nslot_r;
    pslot_nxt    = pslot_r;
    gdx2_nxt     = gdx2_r;
    gdy2_nxt     = gdy2_r;
    r2_nxt       = r2_r;
    outv_nxt     = 1'b0;
    o_added_nxt  = o_added_r;
    o_goal_nxt   = o_goal_r;
    o_full_nxt   = o_full_r;
    o_nx_nxt     = o_nx_r;
    o_ny_nxt     = o_ny_r;
    o_nslot_nxt  = o_nslot_r;
    o_pslot_nxt  = o_pslot_r;
    mem_we       = 1'b0;
    mem_addr     = rd_idx_r[SLOT_W-1:0];
    mem_wdata    = {nx_r, ny_r};
    sreq.go      = 1'b0;
    sreq.from    = best_x_r;
    sreq.to      = sx_r;
    sreq.d2      = best_d_r;
    sreq.s2      = s2_r;

    // scan pipeline: read, square, compare
    p1_v_nxt   = issue;
    p1_idx_nxt = rd_idx_r[SLOT_W-1:0];
    p2_v_nxt   = p1_v_r;
    p2_idx_nxt = p1_idx_r;
    p2_px_nxt  = mem_px;
    p2_py_nxt  = mem_py;
    p2_dx2_nxt = dx * dx;
    p2_dy2_nxt = dy * dy;
    if (p2_v_r && (p2_idx_r == '0 || cand_d < best_d_r)) begin
      best_d_nxt   = cand_d;
      best_idx_nxt = p2_idx_r;
      best_x_nxt   = p2_px_r;
      best_y_nxt   = p2_py_r;
    end

    unique case (state_r)
      // take a request
      T_IDLE: begin
        if (start) begin
          added_nxt = 1'b0;
          full_nxt  = 1'b0;
          nx_nxt    = '0;
          ny_nxt    = '0;
          nslot_nxt = '0;
          pslot_nxt = '0;
          sx_nxt    = in_sample_x;
          sy_nxt    = in_sample_y;
          s2_nxt    = step_r * step_r;
          rd_idx_nxt = '0;
          state_nxt = T_GOAL1;
          if (in_op == OP_RESTART) begin
            mem_we       = 1'b1;
            mem_addr     = '0;
            mem_wdata    = {start_x_r, start_y_r};
            node_cnt_nxt = CNT_W'(1);
            last_x_nxt   = start_x_r;
            last_y_nxt   = start_y_r;
          end else if (in_sample_x <= world_w_r && in_sample_y <= world_h_r &&
                       node_cnt_r != '0) begin
            state_nxt = T_SCAN;
          end
        end
      end
      // one node per cycle until the pipeline drains
      T_SCAN: begin
        if (issue) begin
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
        end
        if (!issue && !p1_v_r && !p2_v_r) begin
          state_nxt = T_DECIDE;
        end
      end
      T_DECIDE: begin
        pslot_nxt = best_idx_r;
        state_nxt = T_GOAL1;
        if (best_d_r > {1'b0, s2_r}) begin
          if (node_cnt_r >= CNT_W'(MAX_NODES)) begin
            full_nxt = 1'b1;
          end else begin
            sreq.go   = 1'b1;
            state_nxt = T_STEP_X;
          end
        end
      end
      // hand the y pass straight on when x finishes
      T_STEP_X: begin
        sreq.from = best_y_r;
        sreq.to   = sy_r;
        if (srsp.done) begin
          nx_nxt    = srsp.coord;
          sreq.go   = 1'b1;
          state_nxt = T_STEP_Y;
        end
      end
      T_STEP_Y: begin
        if (srsp.done) begin
          ny_nxt    = srsp.coord;
          state_nxt = T_WRITE;
        end
      end
      // append the node
      T_WRITE: begin
        mem_we       = 1'b1;
        mem_addr     = node_cnt_r[SLOT_W-1:0];
        nslot_nxt    = node_cnt_r[SLOT_W-1:0];
        node_cnt_nxt = node_cnt_r + CNT_W'(1);
        last_x_nxt   = nx_r;
        last_y_nxt   = ny_r;
        added_nxt    = 1'b1;
        state_nxt    = T_GOAL1;
      end
      T_GOAL1: begin
        gdx2_nxt  = gdx * gdx;
        gdy2_nxt  = gdy * gdy;
        r2_nxt    = radius_r * radius_r;
        state_nxt = T_GOAL2;
      end
      // present the result for one cycle
      T_GOAL2: begin
        outv_nxt    = 1'b1;
        o_added_nxt = added_r;
        o_full_nxt  = full_r;
        o_nx_nxt    = nx_r;
        o_ny_nxt    = ny_r;
        o_nslot_nxt = nslot_r;
        o_pslot_nxt = pslot_r;
        o_goal_nxt  = ({1'b0, gdx2_r} + {1'b0, gdy2_r}) < {1'b0, r2_r};
        state_nxt   = T_IDLE;
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  `RRTNE_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `RRTNE_ASSERT_IMPL(a_add_full, out_valid, !(out_added && out_table_full))
  `RRTNE_ASSERT_IMPL(a_new_slot, out_valid && out_added, out_new_slot != '0)
  `RRTNE_ASSERT_IMPL(a_cnt_range, 1'b1, node_cnt_r <= CNT_W'(MAX_NODES))
endmodule
